// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the line parser and the top level of the fan speed controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/fscc_pkg.sv
// Shared types, constants and speed tables of the fan speed controller
package fscc_pkg;

   // Line framing bytes
   localparam logic [7:0] LF_BYTE      = 8'h0A;
   localparam logic [7:0] CR_BYTE      = 8'h0D;
   localparam logic [7:0] BRACKET_BYTE = 8'h5D;

   // Command words as they appear from line position 1 on
   localparam logic [31:0] TEMP_WORD  = "TEMP";
   localparam logic [39:0] RESET_WORD = "RESET";

   // Value field: three bytes weighted 100, 10, 1, each less 0x30
   localparam int DIGIT_COUNT = 3;
   localparam logic [14:0] WEIGHT_HUNDREDS = 15'd100;
   localparam logic [14:0] WEIGHT_TENS     = 15'd10;
   // 0x30 times 111, taken off the weighted sum of the raw bytes
   localparam logic signed [15:0] VALUE_BIAS = 16'sd5328;

   // Temperature steps
   localparam logic signed [15:0] TEMP_HIGH = 16'sd310;
   localparam logic signed [15:0] TEMP_MID  = 16'sd300;
   localparam logic signed [15:0] TEMP_LOW  = 16'sd290;
   localparam logic [9:0] SPEED_MAX  = 10'd900;
   localparam logic [9:0] SPEED_HIGH = 10'd700;
   localparam logic [9:0] SPEED_MID  = 10'd500;
   localparam logic [9:0] SPEED_BASE = 10'd400;

   // ADC steps: each edge passed adds one speed step
   localparam int ADC_EDGE_COUNT = 9;
   localparam logic [11:0] ADC_EDGES [ADC_EDGE_COUNT] = '{
      12'd410, 12'd820, 12'd1229, 12'd1638, 12'd2048,
      12'd2457, 12'd2867, 12'd3276, 12'd3686
   };
   localparam logic [9:0] SPEED_STEP = 10'd100;

   // Parser result toward the output stage
   typedef struct packed {
      logic [9:0] cmd_speed;
      logic       reset_pulse;
   } parse_result_type;

   // Map a signed line value to the command speed
   function automatic logic [9:0] temp_speed(input logic signed [15:0] value);
      logic [9:0] speed;
      priority if (value > TEMP_HIGH) speed = SPEED_MAX;
      else if (value > TEMP_MID) speed = SPEED_HIGH;
      else if (value > TEMP_LOW) speed = SPEED_MID;
      else speed = SPEED_BASE;
      return speed;
   endfunction

   // Map a 12-bit converter sample to the user speed
   function automatic logic [9:0] adc_speed(input logic [11:0] sample);
      logic [3:0] steps;
      steps = '0;
      for (int i = 0; i < ADC_EDGE_COUNT; i++) begin
         steps = steps + 4'(sample >= ADC_EDGES[i]);
      end
      return SPEED_STEP * (10'(steps) + 10'd1);
   endfunction

endpackage

// File: hw/rtl/fscc_channels.sv
// Handshake channel interfaces for request and response words

interface fscc_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  rx_byte;
   logic [11:0] adc_sample;

   modport source (output valid, command, rx_byte, adc_sample, input ready);
   modport sink   (input valid, command, rx_byte, adc_sample, output ready);
endinterface

interface fscc_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] pwm_compare;
   logic       reset_request;

   modport source (output valid, pwm_compare, reset_request, input ready);
   modport sink   (input valid, pwm_compare, reset_request, output ready);
endinterface

// File: hw/rtl/fscc_line_parser.sv
// Serial command line parser: command letters, value bytes, line end, TEMP and RESET
`include "assert_macros.svh"

module fscc_line_parser #(
   parameter int LINE_LIMIT = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_valid,
   input  logic [7:0]                rx_byte,
   output fscc_pkg::parse_result_type result
);

   localparam int POS_W = $clog2(LINE_LIMIT + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       letters_ff [5];
   logic [7:0]       letters_in [5];
   logic [7:0]       digits_ff [fscc_pkg::DIGIT_COUNT];
   logic [7:0]       digits_in [fscc_pkg::DIGIT_COUNT];
   logic [1:0]       dcount_ff, dcount_in;
   logic             late_ff, late_in;
   logic             last_cr_ff, last_cr_in;
   logic [9:0]       cmd_speed_ff, cmd_speed_in;

   logic                    take;
   logic                    done;
   logic [14:0]             digit_sum;
   logic signed [15:0]      line_value;
   logic                    temp_match;
   logic                    reset_match;

   // Drop bytes once the line has filled
   assign take = byte_valid && (pos_ff < POS_W'(LINE_LIMIT));

   // Fold one byte into the line state
   always_comb begin
      letters_in = letters_ff;
      digits_in  = digits_ff;
      dcount_in  = dcount_ff;
      late_in    = late_ff;
      last_cr_in = last_cr_ff;
      pos_in     = pos_ff;
      done       = 1'b0;
      if (take) begin
         for (int i = 0; i < 5; i++) begin
            if (pos_ff == POS_W'(i + 1)) letters_in[i] = rx_byte;
         end
         if (rx_byte == fscc_pkg::BRACKET_BYTE) begin
            for (int i = 0; i < fscc_pkg::DIGIT_COUNT; i++) digits_in[i] = '0;
            dcount_in = '0;
            late_in   = (pos_ff >= POS_W'(5));
         end else if (dcount_ff != 2'(fscc_pkg::DIGIT_COUNT)) begin
            digits_in[dcount_ff] = rx_byte;
            dcount_in            = dcount_ff + 2'd1;
         end
         last_cr_in = (rx_byte == fscc_pkg::CR_BYTE);
         pos_in     = pos_ff + POS_W'(1);
         done       = (rx_byte == fscc_pkg::LF_BYTE) && last_cr_ff && (pos_ff != '0);
      end
   end

   // Value of the line; missing value bytes stay zero and count as -0x30
   assign digit_sum  = 15'(digits_in[0]) * fscc_pkg::WEIGHT_HUNDREDS
                     + 15'(digits_in[1]) * fscc_pkg::WEIGHT_TENS
                     + 15'(digits_in[2]);
   assign line_value = $signed({1'b0, digit_sum}) - fscc_pkg::VALUE_BIAS;

   // Match the command words against the stored letters
   assign temp_match  = late_in
      && ({letters_in[0], letters_in[1], letters_in[2], letters_in[3]}
          == fscc_pkg::TEMP_WORD);
   assign reset_match = late_in
      && ({letters_in[0], letters_in[1], letters_in[2], letters_in[3], letters_in[4]}
          == fscc_pkg::RESET_WORD);

   // Update the command speed when a TEMP line completes
   assign cmd_speed_in = (done && temp_match) ? fscc_pkg::temp_speed(line_value)
                                              : cmd_speed_ff;

   assign result.cmd_speed   = cmd_speed_in;
   assign result.reset_pulse = done && !temp_match && reset_match;

   // Advance the line state, clear it at line end
   always_ff @(posedge clock) begin
      if (reset || done) begin
         pos_ff     <= '0;
         dcount_ff  <= '0;
         late_ff    <= 1'b0;
         last_cr_ff <= 1'b0;
         for (int i = 0; i < 5; i++) letters_ff[i] <= '0;
         for (int i = 0; i < fscc_pkg::DIGIT_COUNT; i++) digits_ff[i] <= '0;
      end else begin
         pos_ff     <= pos_in;
         dcount_ff  <= dcount_in;
         late_ff    <= late_in;
         last_cr_ff <= last_cr_in;
         letters_ff <= letters_in;
         digits_ff  <= digits_in;
      end
   end

   // Hold the command speed across lines
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_speed_ff <= '0;
      end else begin
         cmd_speed_ff <= cmd_speed_in;
      end
   end

   `ASSERT_IMPLIES(a_pos_bound, 1'b1, pos_ff <= POS_W'(LINE_LIMIT), "line position past limit")
   `ASSERT_NEXT(a_line_clear, done, (pos_ff == '0) && !last_cr_ff && (dcount_ff == '0), "line state not cleared after line end")

endmodule

// File: hw/rtl/fscc_adc_speed.sv
// User speed register fed by the ADC step table
module fscc_adc_speed (
   input  logic        clock,
   input  logic        reset,
   input  logic        sample_valid,
   input  logic [11:0] adc_sample,
   output logic [9:0]  adc_speed
);

   logic [9:0] speed_ff, speed_in;

   // Map a new sample, otherwise keep the last speed
   assign speed_in  = sample_valid ? fscc_pkg::adc_speed(adc_sample) : speed_ff;
   assign adc_speed = speed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
      end else begin
         speed_ff <= speed_in;
      end
   end

endmodule

// File: hw/rtl/fan_speed_command_controller_core.sv
// Top level of the fan speed controller: input stage, speed sources, result stage
//
// Takes one word per cycle on req_chan: a serial byte (command 0) or a 12-bit ADC
// sample (command 1), and returns exactly one word per accepted word on rsp_chan,
// through the input register and then the result register. Serial bytes build lines of
// the form [CMD]ddd CR LF; a TEMP line sets the command speed from its three value
// bytes, a RESET line raises reset_request on the word of its closing LF. Samples
// set the user speed through a ten-step table. csr_wdata written with csr_we picks
// the speed on pwm_compare: 0 command speed, 1 user speed. Lines longer than
// LINE_LIMIT bytes drop further bytes. Throughput is one word per cycle, set by
// the input register and result register, which stall only when rsp_chan holds
// a waiting word and is not ready.
`include "assert_macros.svh"

module fan_speed_command_controller_core #(
   parameter int LINE_LIMIT = 256
) (
   input  logic            clock,
   input  logic            reset,
   fscc_req_if.sink        req_chan,
   fscc_rsp_if.source      rsp_chan,
   input  logic            csr_we,
   input  logic            csr_wdata
);

   logic        mode_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_cmd_ff;
   logic [7:0]  s1_byte_ff;
   logic [11:0] s1_sample_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  rsp_pwm_ff;
   logic        rsp_reset_ff;

   logic                       s1_adv;
   logic                       req_take;
   logic [9:0]                 adc_speed;
   fscc_pkg::parse_result_type parse;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // Handshake: the input stage advances when the result register is free
   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the input word
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff    <= req_chan.command;
         s1_byte_ff   <= req_chan.rx_byte;
         s1_sample_ff <= req_chan.adc_sample;
      end
   end

   // Speed sources, updated as the word leaves the input stage
   fscc_line_parser #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (s1_adv && !s1_cmd_ff),
      .rx_byte    (s1_byte_ff),
      .result     (parse)
   );

   fscc_adc_speed u_adc (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (s1_adv && s1_cmd_ff),
      .adc_sample   (s1_sample_ff),
      .adc_speed    (adc_speed)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pwm_ff   <= mode_ff ? adc_speed : parse.cmd_speed;
         rsp_reset_ff <= parse.reset_pulse;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pwm_compare   = rsp_pwm_ff;
   assign rsp_chan.reset_request = rsp_reset_ff;

   `ASSERT_NEXT(a_result_fill, s1_adv, rsp_valid_ff, "advanced word missing from result register")
   `ASSERT_IMPLIES(a_pwm_range, rsp_valid_ff, rsp_pwm_ff <= 10'd1000, "compare value out of range")
   `ASSERT_IMPLIES(a_stall_cause, !req_chan.ready, s1_valid_ff && rsp_valid_ff, "input stalled with a free stage")

endmodule

// File: bench/tb.sv
// Self-checking bench for the fan speed command controller: directed table, random lines, an overlong line, random tail
`timescale 1ns / 1ps

module tb;

   // Word kinds on the request channel
   localparam logic CMD_BYTE   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Speed source select
   localparam logic MODE_AUTO = 1'b0;
   localparam logic MODE_USER = 1'b1;

   // Line framing bytes
   localparam logic [7:0] LF            = 8'h0A;
   localparam logic [7:0] CR            = 8'h0D;
   localparam logic [7:0] OPEN_BRACKET  = 8'h5B;
   localparam logic [7:0] CLOSE_BRACKET = 8'h5D;
   localparam logic [7:0] ZERO_CHAR     = 8'h30;

   localparam int LINE_MAX        = 256;
   localparam int RSP_HOLD_CYCLES = 80;

   typedef struct packed {
      logic [9:0] pwm;
      logic       reset_req;
   } fan_word_t;

   typedef struct packed {
      logic        mode;
      logic        command;
      logic [7:0]  rx_byte;
      logic [11:0] sample;
      logic        known;
      logic [9:0]  pwm;
      logic        reset_req;
   } script_row_t;

   // Directed words: sample extremes in user mode, then a TEMP line and a RESET line
   script_row_t script_rows [25] = '{
      '{MODE_USER, CMD_SAMPLE, 8'h00, 12'd0,    1'b1, 10'd100,  1'b0},
      '{MODE_USER, CMD_SAMPLE, 8'hFF, 12'd409,  1'b1, 10'd100,  1'b0},
      '{MODE_USER, CMD_SAMPLE, 8'h00, 12'd410,  1'b1, 10'd200,  1'b0},
      '{MODE_USER, CMD_SAMPLE, 8'hFF, 12'd3686, 1'b1, 10'd1000, 1'b0},
      '{MODE_USER, CMD_SAMPLE, 8'h00, 12'd4095, 1'b1, 10'd1000, 1'b0},
      '{MODE_AUTO, CMD_BYTE,   "[",   12'd4095, 1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "T",   12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "E",   12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "M",   12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "P",   12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "]",   12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "3",   12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "1",   12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "1",   12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   CR,    12'd0,    1'b1, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   LF,    12'd0,    1'b1, 10'd900,  1'b0},
      '{MODE_AUTO, CMD_BYTE,   "[",   12'd0,    1'b0, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "R",   12'd0,    1'b0, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "E",   12'd0,    1'b0, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "S",   12'd0,    1'b0, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "E",   12'd0,    1'b0, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "T",   12'd0,    1'b0, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   "]",   12'd0,    1'b0, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   CR,    12'd0,    1'b0, 10'd0,    1'b0},
      '{MODE_AUTO, CMD_BYTE,   LF,    12'd0,    1'b1, 10'd900,  1'b1}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   fscc_req_if req_chan ();
   fscc_rsp_if rsp_chan ();

   fan_speed_command_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Bench control
   bit        send_idle     = 1'b1;
   bit        rsp_idle      = 1'b1;
   bit        rsp_hold_long = 1'b0;
   int        words_sent    = 0;
   int        error_count   = 0;
   fan_word_t speed_words_due [$];

   // Shadow of the controller state
   logic       pick_user;
   int         fill_pos;
   logic [7:0] head_bytes [5];
   int         val_digits;
   int         val_sum;
   logic       prev_cr;
   logic       bracket_late;
   logic [9:0] auto_speed;
   logic [9:0] user_speed;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [9:0] temp_to_speed(input int degrees);
      if (degrees > 310) return 10'd900;
      if (degrees > 300) return 10'd700;
      if (degrees > 290) return 10'd500;
      return 10'd400;
   endfunction

   function automatic int sample_step_edge(input int idx);
      case (idx)
         0: return 410;
         1: return 820;
         2: return 1229;
         3: return 1638;
         4: return 2048;
         5: return 2457;
         6: return 2867;
         7: return 3276;
         default: return 3686;
      endcase
   endfunction

   function automatic logic [9:0] sample_to_speed(input logic [11:0] s);
      int steps;
      steps = 0;
      while (steps < 9 && int'(s) >= sample_step_edge(steps)) steps++;
      return 10'(100 * (steps + 1));
   endfunction

   function automatic void clear_line_state();
      fill_pos = 0;
      foreach (head_bytes[i]) head_bytes[i] = 8'h00;
      val_digits   = 0;
      val_sum      = 0;
      prev_cr      = 1'b0;
      bracket_late = 1'b0;
   endfunction

   // Advance the shadow state by one accepted word and return the word it answers with
   function automatic fan_word_t next_fan_word(input logic cmd, input logic [7:0] rx,
                                               input logic [11:0] s);
      fan_word_t w;
      int        pos;
      int        v;
      int        c;
      logic      line_end;
      w.reset_req = 1'b0;
      if (cmd == CMD_SAMPLE) begin
         user_speed = sample_to_speed(s);
      end else if (fill_pos < LINE_MAX) begin
         pos = fill_pos;
         if (pos >= 1 && pos <= 5) head_bytes[pos - 1] = rx;
         // a closing bracket restarts the value field
         if (rx == CLOSE_BRACKET) begin
            val_digits   = 0;
            val_sum      = 0;
            bracket_late = (pos >= 5);
         end else if (val_digits < 3) begin
            val_sum = val_sum * 10 + int'(rx) - int'(ZERO_CHAR);
            val_digits++;
         end
         line_end = (rx == LF) && prev_cr && (pos >= 1);
         prev_cr  = (rx == CR);
         fill_pos = pos + 1;
         if (line_end) begin
            // missing value bytes count as zero bytes
            v = val_sum;
            for (c = val_digits; c < 3; c++) v = v * 10 - int'(ZERO_CHAR);
            if (bracket_late &&
                {head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3]} == "TEMP") begin
               auto_speed = temp_to_speed(v);
            end else if (bracket_late && {head_bytes[0], head_bytes[1], head_bytes[2],
                                          head_bytes[3], head_bytes[4]} == "RESET") begin
               w.reset_req = 1'b1;
            end
            clear_line_state();
         end
      end
      w.pwm = pick_user ? user_speed : auto_speed;
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Offer one word, hold it until accepted, then queue its expected result
   task automatic send_word(input logic cmd, input logic [7:0] rx, input logic [11:0] s,
                            input logic known, input fan_word_t typed_word);
      fan_word_t due;
      if (send_idle && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.rx_byte    <= rx;
      req_chan.adc_sample <= s;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      due = next_fan_word(cmd, rx, s);
      speed_words_due.push_back(known ? typed_word : due);
      words_sent++;
   endtask

   function automatic logic [11:0] pick_sample();
      int e;
      if ($urandom_range(0, 2) == 0) begin
         e = sample_step_edge($urandom_range(0, 8)) - $urandom_range(0, 1);
         return 12'(e);
      end
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == LF) ? 8'hFF : b;
   endfunction

   task automatic send_sample(input logic [11:0] s);
      send_word(CMD_SAMPLE, 8'($urandom_range(0, 255)), s, 1'b0, '0);
   endtask

   // Send a serial byte, now and then with a sample slipped in ahead of it
   task automatic send_byte(input logic [7:0] rx);
      if ($urandom_range(0, 11) == 0) send_sample(pick_sample());
      send_word(CMD_BYTE, rx, 12'($urandom_range(0, 4095)), 1'b0, '0);
   endtask

   task automatic send_text(input string txt);
      int k;
      for (k = 0; k < txt.len(); k++) send_byte(txt[k]);
   endtask

   // Mostly well-formed command lines with random content, some noise and broken lines
   task automatic send_line();
      string      word_pick;
      logic [7:0] hdr;
      logic [7:0] val_bytes [5];
      int         kind;
      int         broken;
      int         n_val;
      int         temp_val;
      int         k;
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
         repeat ($urandom_range(1, 4)) send_sample(pick_sample());
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
         broken = (kind == 6) ? $urandom_range(1, 3) : 0;
         case ($urandom_range(0, 9))
            0, 1, 2: word_pick = "TEMP";
            3, 4:    word_pick = "RESET";
            5:       word_pick = "TEMPO";
            6:       word_pick = "RESETX";
            7:       word_pick = "TEM";
            8:       word_pick = "RESE";
            default: word_pick = "";
         endcase
         n_val    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : 3;
         temp_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999)
                                                : $urandom_range(285, 315);
         val_bytes[0] = ZERO_CHAR + 8'(temp_val / 100);
         val_bytes[1] = ZERO_CHAR + 8'((temp_val / 10) % 10);
         val_bytes[2] = ZERO_CHAR + 8'(temp_val % 10);
         val_bytes[3] = ZERO_CHAR + 8'($urandom_range(0, 9));
         val_bytes[4] = ZERO_CHAR + 8'($urandom_range(0, 9));
         if ($urandom_range(0, 7) == 0) val_bytes[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
         hdr = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : OPEN_BRACKET;
         send_byte(hdr);
         send_text(word_pick);
         // a lone LF mid-line is stored and the line goes on
         if (broken == 1) send_byte(LF);
         send_byte(CLOSE_BRACKET);
         for (k = 0; k < n_val; k++) send_byte(val_bytes[k]);
         if (broken != 2) send_byte(CR);
         if (broken == 3) send_byte(8'($urandom_range(0, 255)));
         send_byte(LF);
      end
   endtask

   // Fill one line up to the limit, then keep sending so that the rest is dropped
   task automatic send_long_lines();
      int k;
      send_text("[TEMP]");
      send_byte(ZERO_CHAR + 8'($urandom_range(2, 3)));
      send_byte(ZERO_CHAR + 8'($urandom_range(0, 9)));
      send_byte(ZERO_CHAR + 8'($urandom_range(0, 9)));
      for (k = 9; k < LINE_MAX; k++) send_byte(filler_byte());
      // everything past the limit is dropped, this line end too
      send_text("[TEMP]299");
      send_byte(CR);
      send_byte(LF);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (speed_words_due.size() != 0) @(posedge clock);
   endtask

   // Write the mode register once every queued result has come back
   task automatic write_mode(input logic mode);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
      pick_user = mode;
   endtask

   task automatic send_random_lines(input int count);
      int stop_at;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 24) == 0) send_idle = !send_idle;
         if ($urandom_range(0, 24) == 0) rsp_idle = !rsp_idle;
         send_line();
      end
   endtask

   // Drive response ready: random stall bursts, and one long hold when asked
   initial begin : rsp_ready_drive
      int run_len;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_long) begin
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_long = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (rsp_idle && $urandom_range(0, 6) == 0) begin
            rsp_chan.ready <= 1'b0;
            run_len = $urandom_range(1, 14);
            repeat (run_len) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin : result_check
      fan_word_t due;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (speed_words_due.size() == 0) begin
            report_mismatch("result word with none expected");
         end else begin
            due = speed_words_due.pop_front();
            if (rsp_chan.pwm_compare !== due.pwm)
               report_mismatch($sformatf("pwm_compare %0d, expected %0d",
                                         rsp_chan.pwm_compare, due.pwm));
            if (rsp_chan.reset_request !== due.reset_req)
               report_mismatch($sformatf("reset_request %0b, expected %0b",
                                         rsp_chan.reset_request, due.reset_req));
         end
      end
   end

   initial begin : stimulus
      fan_word_t typed_word;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= 1'b0;
      req_chan.valid      <= 1'b0;
      req_chan.command    <= CMD_BYTE;
      req_chan.rx_byte    <= 8'h00;
      req_chan.adc_sample <= 12'd0;
      pick_user  = MODE_AUTO;
      auto_speed = 10'd0;
      user_speed = 10'd0;
      clear_line_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table, switching mode where a row asks for it
      foreach (script_rows[i]) begin
         if (script_rows[i].mode != pick_user) write_mode(script_rows[i].mode);
         typed_word = {script_rows[i].pwm, script_rows[i].reset_req};
         send_word(script_rows[i].command, script_rows[i].rx_byte, script_rows[i].sample,
                   script_rows[i].known, typed_word);
      end

      // Random lines on the command speed
      write_mode(MODE_AUTO);
      send_random_lines(40);

      // Random lines on the user speed, opening with a long receiver hold
      write_mode(MODE_USER);
      send_idle     = 1'b0;
      rsp_hold_long = 1'b1;
      send_random_lines(30);

      // Line length limit: an overrun that jams the parser
      write_mode(MODE_AUTO);
      send_long_lines();

      // Tail with no idling on either side
      write_mode(MODE_USER);
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      repeat (40) begin
         if ($urandom_range(0, 1) == 0) send_sample(pick_sample());
         else send_byte(8'($urandom_range(0, 255)));
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : run_limit
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fscc_pkg.sv
hw/rtl/fscc_channels.sv
hw/rtl/fscc_line_parser.sv
hw/rtl/fscc_adc_speed.sv
hw/rtl/fan_speed_command_controller_core.sv
bench/tb.sv
